FILE: hdl/sobel_pkg.sv
// Shared types and constants for the RGB Sobel edge-magnitude block.
// Used by sobel_window, sobel_lane and sobel_edge_magnitude_rgb.
package sobel_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_RESET      = 1024;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // input item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // largest Gx^2+Gy^2 whose rounded root still fits in 8 bits (rounds to 255)
  localparam logic [20:0] SAT_SUM = 21'd65280;
  localparam logic [7:0]  MAG_MAX = 8'd255;

  // channel 0 blue, 1 green, 2 red
  typedef logic [2:0][PIX_W-1:0] rgb_t;
  // [row][col][channel]
  typedef rgb_t [2:0][2:0] taps_t;
  // [row][col] of one channel
  typedef logic [2:0][2:0][PIX_W-1:0] ch_taps_t;

  typedef struct packed {
    logic emit;
    logic last;
  } win_sts_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_sts_t;

endpackage

FILE: hdl/sobel_edge_magnitude_rgb.sv
// Top level: RGB Sobel edge magnitude with three channel lanes and a merge stage.
// Depends on sobel_pkg, sobel_window and sobel_lane.
//
//   port group   dir  handshake          word
//   in_*         in   in_valid/in_stall   func, blue_in, green_in, red_in
//   out_*        out  out_valid/out_stall blue_edge, green_edge, red_edge, frame_last
//   cfg_*        in   cfg_valid/cfg_ready index 0 image_width, 1 image_height
//
// An item that yields no word only passes the step and evaluate states; one that
// yields a word also waits for all three lanes, each running an 8-step root loop
// unless its channel saturates. One item is in flight at a time; a finished word
// waits in the output register, held by out_stall, while the next item is taken.
// Reset (rst_n low, synchronous) restores 1024 x 1024 geometry, starts a new frame.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [7:0]                       in_blue_in,
  input  logic [7:0]                       in_green_in,
  input  logic [7:0]                       in_red_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_blue_edge,
  output logic [7:0]                       out_green_edge,
  output logic [7:0]                       out_red_edge,
  output logic                             out_frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sobel_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STEP  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_LANES = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic      in_acc, cfg_we, out_free, out_load, all_done, all_active;
  taps_t     taps;
  win_sts_t  wsts;
  lane_ctl_t lane_ctl;
  lane_sts_t lane_sts [3];
  ch_taps_t  lane_taps [3];
  logic [2:0]       done_vec, active_vec;
  logic [2:0][7:0]  lane_mag;

  logic out_valid_r, out_valid_nxt, out_last_r;
  rgb_t out_rgb_r;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign cfg_we    = cfg_valid && cfg_ready;

  sobel_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .load     (in_acc),
    .func     (in_func),
    .pix      (rgb_t'({in_red_in, in_green_in, in_blue_in})),
    .step     (state_r == S_STEP),
    .taps     (taps),
    .sts      (wsts)
  );

  assign lane_ctl.start = (state_r == S_EVAL) && wsts.emit;
  assign lane_ctl.ack   = out_load;

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
        assign lane_taps[ch][r][c] = taps[r][c][ch];
      end
    end

    sobel_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .taps  (lane_taps[ch]),
      .ctl   (lane_ctl),
      .sts   (lane_sts[ch]),
      .mag   (lane_mag[ch])
    );

    assign done_vec[ch]   = lane_sts[ch].done;
    assign active_vec[ch] = lane_sts[ch].busy || lane_sts[ch].done;
  end

  assign all_done   = &done_vec;
  assign all_active = &active_vec;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_load   = (state_r == S_LANES) && all_done && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_STEP;
      S_STEP:  state_nxt = S_EVAL;
      S_EVAL:  state_nxt = wsts.emit ? S_LANES : S_IDLE;
      S_LANES: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // merge: the three lane results and the frame flag form one word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rgb_r  <= lane_mag;
      out_last_r <= wsts.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blue_edge  = out_rgb_r[0];
  assign out_green_edge = out_rgb_r[1];
  assign out_red_edge   = out_rgb_r[2];
  assign out_frame_last = out_last_r;

  a_lanes_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LANES) |-> all_active)
    else $error("waiting on lanes that were never started");

endmodule

FILE: hdl/sobel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sobel_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sobel_window.sv
// Line stores, 3x3 window, raster counters and frame geometry registers.
// Depends on sobel_pkg and sobel_ram.
module sobel_window #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             load,
  input  logic                             func,
  input  sobel_pkg::rgb_t                  pix,
  input  logic                             step,
  output sobel_pkg::taps_t                 taps,
  output sobel_pkg::win_sts_t              sts
);
  import sobel_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  function automatic logic [31:0] clamp_dim(logic [31:0] v, logic [31:0] maxv);
    logic [31:0] res;
    res = v;
    if (v == 32'd0) begin
      res = 32'd1;
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

  localparam logic [WW-1:0] W_RESET = WW'(clamp_dim(32'(DIM_RESET), 32'(MAX_WIDTH)));
  localparam logic [HW-1:0] H_RESET = HW'(clamp_dim(32'(DIM_RESET), 32'(MAX_HEIGHT)));

  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [CW-1:0] ic_r, ic_nxt;
  logic [RW-1:0] ir_r, ir_nxt;
  taps_t         win_r, win_nxt;
  win_sts_t      sts_r, sts_nxt;
  taps_t         taps_r, taps_nxt;
  rgb_t          px_r;
  logic          cfg_hit;

  rgb_t ram_up_q, ram_lo_q, up, lo;
  logic col0, ic_wrap, emit, last, mask_left;

  // u_row_upper holds row-2, u_row_lower holds row-1
  sobel_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_row_upper (
    .clk   (clk),
    .we    (step),
    .waddr (ic_r),
    .wdata (lo),
    .re    (load),
    .raddr (ic_r),
    .rdata (ram_up_q)
  );

  sobel_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_row_lower (
    .clk   (clk),
    .we    (step),
    .waddr (ic_r),
    .wdata (px_r),
    .re    (load),
    .raddr (ic_r),
    .rdata (ram_lo_q)
  );

  always_comb begin
    cfg_hit = 1'b0;
    w_nxt   = w_r;
    h_nxt   = h_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH: begin
          cfg_hit = 1'b1;
          w_nxt   = WW'(clamp_dim(32'(cfg_data), 32'(MAX_WIDTH)));
        end
        REG_IMAGE_HEIGHT: begin
          cfg_hit = 1'b1;
          h_nxt   = HW'(clamp_dim(32'(cfg_data), 32'(MAX_HEIGHT)));
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    up      = (ir_r >= RW'(2)) ? ram_up_q : '0;
    lo      = (ir_r >= RW'(1)) ? ram_lo_q : '0;
    col0    = (ic_r == '0);
    ic_wrap = ((WW'(ic_r) + WW'(1)) == w_r);
    // nothing leaves until the window has seen one row plus one pixel
    emit    = !((ir_r == '0) || ((ir_r == RW'(1)) && col0));
    // at column 0 the output is the right edge of the row above
    last    = emit && col0 && (ir_r > RW'(h_r));
    mask_left = col0 ? (w_r == WW'(1)) : (ic_r == CW'(1));

    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = up;
    win_nxt[1][2] = lo;
    win_nxt[2][2] = px_r;

    for (int r = 0; r < 3; r++) begin
      if (col0) begin
        taps_nxt[r][0] = win_r[r][1];
        taps_nxt[r][1] = win_r[r][2];
        taps_nxt[r][2] = '0;
      end else begin
        taps_nxt[r] = win_nxt[r];
      end
      if (mask_left) begin
        taps_nxt[r][0] = '0;
      end
    end

    if (ic_wrap) begin
      ic_nxt = '0;
      ir_nxt = ir_r + RW'(1);
    end else begin
      ic_nxt = ic_r + CW'(1);
      ir_nxt = ir_r;
    end

    sts_nxt.emit = emit;
    sts_nxt.last = last;

    // frame done: start over
    if (last) begin
      ic_nxt  = '0;
      ir_nxt  = '0;
      win_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= W_RESET;
      h_r   <= H_RESET;
      ic_r  <= '0;
      ir_r  <= '0;
      win_r <= '0;
      sts_r <= '0;
    end else if (cfg_hit) begin
      w_r   <= w_nxt;
      h_r   <= h_nxt;
      ic_r  <= '0;
      ir_r  <= '0;
      win_r <= '0;
    end else if (step) begin
      ic_r  <= ic_nxt;
      ir_r  <= ir_nxt;
      win_r <= win_nxt;
      sts_r <= sts_nxt;
    end
  end

  // flush items and pixels past the last row count as padding
  always_ff @(posedge clk) begin
    if (load) begin
      px_r <= ((func == FUNC_PIXEL) && (ir_r < RW'(h_r))) ? pix : '0;
    end
    if (step) begin
      taps_r <= taps_nxt;
    end
  end

  assign taps = taps_r;
  assign sts  = sts_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(ic_r) < w_r)
    else $error("column counter outside the row");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ir_r <= (RW'(h_r) + RW'(1)))
    else $error("row counter ran past the frame end");

endmodule

FILE: hdl/sobel_lane.sv
// One channel lane: Sobel gradients, squares, and a bit-serial rounded root.
// Depends on sobel_pkg.
module sobel_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sobel_pkg::ch_taps_t  taps,
  input  sobel_pkg::lane_ctl_t ctl,
  output sobel_pkg::lane_sts_t sts,
  output logic [7:0]           mag
);
  import sobel_pkg::*;

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_SQR  = 6'b000010,
    L_SUM  = 6'b000100,
    L_ROOT = 6'b001000,
    L_RND  = 6'b010000,
    L_DONE = 6'b100000
  } lane_state_t;

  lane_state_t state_r, state_nxt;

  logic signed [10:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic [19:0] sqx_r, sqy_r;
  logic [15:0] s_r;
  logic [7:0]  root_r, root_nxt, mag_r, mag_nxt;
  logic [2:0]  bit_r;

  logic [9:0]  xp, xn, yp, yn, ax, ay;
  logic [20:0] s_full;
  logic [7:0]  t;
  logic [15:0] tt, rr;
  logic        rnd;

  always_comb begin
    xp = 10'(taps[0][2]) + 10'({taps[1][2], 1'b0}) + 10'(taps[2][2]);
    xn = 10'(taps[0][0]) + 10'({taps[1][0], 1'b0}) + 10'(taps[2][0]);
    yp = 10'(taps[2][0]) + 10'({taps[2][1], 1'b0}) + 10'(taps[2][2]);
    yn = 10'(taps[0][0]) + 10'({taps[0][1], 1'b0}) + 10'(taps[0][2]);
    gx_nxt = $signed({1'b0, xp}) - $signed({1'b0, xn});
    gy_nxt = $signed({1'b0, yp}) - $signed({1'b0, yn});

    ax = gx_r[10] ? 10'(-gx_r) : gx_r[9:0];
    ay = gy_r[10] ? 10'(-gy_r) : gy_r[9:0];

    s_full = 21'(sqx_r) + 21'(sqy_r);

    t  = root_r | (8'd1 << bit_r);
    tt = t * t;
    root_nxt = (tt <= s_r) ? t : root_r;

    // round to nearest: s > r*r + r
    rr  = 16'(root_r * root_r) + 16'(root_r);
    rnd = (s_r > rr);
    mag_nxt = root_r + {7'd0, rnd};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (ctl.start) state_nxt = L_SQR;
      L_SQR:  state_nxt = L_SUM;
      L_SUM:  state_nxt = (s_full > SAT_SUM) ? L_DONE : L_ROOT;
      L_ROOT: if (bit_r == 3'd0) state_nxt = L_RND;
      L_RND:  state_nxt = L_DONE;
      L_DONE: if (ctl.ack) state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && ctl.start) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
    if (state_r == L_SQR) begin
      sqx_r <= ax * ax;
      sqy_r <= ay * ay;
    end
    if (state_r == L_SUM) begin
      s_r    <= s_full[15:0];
      root_r <= '0;
      bit_r  <= 3'd7;
      mag_r  <= MAG_MAX;
    end
    if (state_r == L_ROOT) begin
      root_r <= root_nxt;
      bit_r  <= bit_r - 3'd1;
    end
    if (state_r == L_RND) begin
      mag_r <= mag_nxt;
    end
  end

  assign sts.busy = (state_r != L_IDLE) && (state_r != L_DONE);
  assign sts.done = (state_r == L_DONE);
  assign mag      = mag_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> (state_r == L_IDLE))
    else $error("lane started while working");

  a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ack |-> (state_r == L_DONE))
    else $error("lane result taken before it was ready");

endmodule
